/* rtl/mst_pkg.sv */
// Shared types and constants for the spanning tree engine.
`timescale 1ns / 1ps
package mst_pkg;

   localparam int NODE_W    = 4;
   localparam int WEIGHT_W  = 16;
   localparam int TOTAL_W   = 20;
   localparam int MAX_NODES = 1 << NODE_W;
   localparam int MAX_EDGES = 32;
   localparam int EDGE_AW   = $clog2(MAX_EDGES);
   localparam int COUNT_W   = $clog2(MAX_EDGES + 1);
   localparam int EDGE_W    = 1 + 2 * NODE_W + WEIGHT_W;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // Operation codes of an input transaction.
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Command kinds passed from the front to the back.
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]          operation;
      logic [NODE_W-1:0]   from_node;
      logic [NODE_W-1:0]   to_node;
      logic [WEIGHT_W-1:0] weight;
      logic                both_ways;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]   parent_node;
      logic [NODE_W-1:0]   child_node;
      logic [WEIGHT_W-1:0] edge_weight;
      logic [TOTAL_W-1:0]  total_weight;
      logic                edge_valid;
      logic                store_overflowed;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic                both_ways;
      logic [NODE_W-1:0]   from_node;
      logic [NODE_W-1:0]   to_node;
      logic [WEIGHT_W-1:0] weight;
   } edge_type;

   typedef struct packed {
      logic [1:0] kind;
      edge_type   edge_data;
   } cmd_type;

   // Field order gives the tie break: weight, then child, then parent.
   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [NODE_W-1:0]   child;
      logic [NODE_W-1:0]   parent;
   } key_type;

   typedef struct packed {
      logic               busy;
      logic [COUNT_W-1:0] edge_count;
   } status_type;

endpackage

/* rtl/mst_ram.sv */
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module mst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mst_front.sv */
// Front end: accepts input transactions, classifies them and queues commands.
`timescale 1ns / 1ps
module mst_front
   import mst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type    q_ff [2];
   cmd_type    q_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       accept, enq, deq, known;

   assign full   = (cnt_ff == 2'd2);
   assign accept = push && !full;
   assign deq    = cmd_pop && (cnt_ff != 2'd0);

   always_comb begin
      q_in.edge_data.both_ways = req_data.both_ways;
      q_in.edge_data.from_node = req_data.from_node;
      q_in.edge_data.to_node   = req_data.to_node;
      q_in.edge_data.weight    = req_data.weight;
      known = 1'b1;
      unique case (req_data.operation)
         OP_ADD:   q_in.kind = CMD_ADD;
         OP_RUN:   q_in.kind = CMD_RUN;
         OP_CLEAR: q_in.kind = CMD_CLEAR;
         default: begin
            // The unused code is taken and dropped here.
            q_in.kind = CMD_CLEAR;
            known     = 1'b0;
         end
      endcase
   end

   assign enq       = accept && known;
   assign wr_ptr_in = enq ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = deq ? !rd_ptr_ff : rd_ptr_ff;
   assign cnt_in    = cnt_ff + {1'b0, enq} - {1'b0, deq};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (enq) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

endmodule

/* rtl/mst_back.sv */
// Back end: edge store control, tree growth sweeps and the result register.
`timescale 1ns / 1ps
module mst_back
   import mst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp_data,
   output status_type status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SWEEP  = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [COUNT_W-1:0]   ptr_ff, ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rdv_ff, rdv_in;
   logic                 ovf_ff, ovf_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in;
   key_type              best_ff, best_in;
   logic                 best_valid_ff, best_valid_in;
   rsp_type              pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   rsp_type              out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;

   logic               we, issue, out_free;
   logic [EDGE_W-1:0]  rd_word;
   edge_type           edge_rd;
   logic               offer_fwd, offer_rev, cand_valid;
   key_type            cand;
   logic [TOTAL_W:0]   sum_wide;
   logic [TOTAL_W-1:0] sum_sat;

   mst_ram #(
      .WIDTH(EDGE_W),
      .DEPTH(MAX_EDGES)
   ) u_store (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (count_ff[EDGE_AW-1:0]),
      .wr_data (cmd.edge_data),
      .rd_en   (issue),
      .rd_addr (ptr_ff[EDGE_AW-1:0]),
      .rd_data (rd_word)
   );

   assign edge_rd = edge_type'(rd_word);

   // At most one direction of an edge can cross the visited boundary.
   assign offer_fwd  = visited_ff[edge_rd.from_node] && !visited_ff[edge_rd.to_node];
   assign offer_rev  = edge_rd.both_ways && visited_ff[edge_rd.to_node]
                       && !visited_ff[edge_rd.from_node];
   assign cand_valid = offer_fwd || offer_rev;
   assign cand = offer_fwd ? key_type'{edge_rd.weight, edge_rd.to_node, edge_rd.from_node}
                           : key_type'{edge_rd.weight, edge_rd.from_node, edge_rd.to_node};

   assign sum_wide = {1'b0, total_ff} + (TOTAL_W + 1)'(best_ff.weight);
   assign sum_sat  = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
   assign out_free = !out_valid_ff || pop;

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      visited_in    = visited_ff;
      best_in       = best_ff;
      best_valid_in = best_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      total_in      = total_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      cmd_pop       = 1'b0;
      we            = 1'b0;
      issue         = 1'b0;

      if (out_valid_ff && pop) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  CMD_ADD: begin
                     if (count_ff == COUNT_W'(MAX_EDGES)) begin
                        ovf_in = 1'b1;
                     end else begin
                        we       = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_RUN: begin
                     visited_in    = MAX_NODES'(1);
                     total_in      = '0;
                     pend_valid_in = 1'b0;
                     best_valid_in = 1'b0;
                     ptr_in        = '0;
                     state_in      = ST_SWEEP;
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SWEEP: begin
            if (ptr_ff < count_ff) begin
               issue  = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end
            if (rdv_ff && cand_valid && (!best_valid_ff || cand < best_ff)) begin
               best_in       = cand;
               best_valid_in = 1'b1;
            end
            if (ptr_ff == count_ff && !rdv_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // A found edge is held back until the next sweep shows whether it is the last.
            if (best_valid_ff) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     out_in       = pend_ff;
                     out_valid_in = 1'b1;
                  end
                  pend_in       = '{best_ff.parent, best_ff.child, best_ff.weight,
                                    sum_sat, 1'b1, ovf_ff, 1'b0};
                  pend_valid_in = 1'b1;
                  total_in      = sum_sat;
                  visited_in    = visited_ff | (MAX_NODES'(1) << best_ff.child);
                  best_valid_in = 1'b0;
                  ptr_in        = '0;
                  state_in      = ST_SWEEP;
               end
            end else if (out_free) begin
               if (pend_valid_ff) begin
                  out_in      = pend_ff;
                  out_in.last = 1'b1;
               end else begin
                  out_in = '{'0, '0, '0, '0, 1'b0, ovf_ff, 1'b1};
               end
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rdv_in = issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ptr_ff        <= '0;
         count_ff      <= '0;
         rdv_ff        <= 1'b0;
         ovf_ff        <= 1'b0;
         visited_ff    <= '0;
         best_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         total_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         count_ff      <= count_in;
         rdv_ff        <= rdv_in;
         ovf_ff        <= ovf_in;
         visited_ff    <= visited_in;
         best_valid_ff <= best_valid_in;
         pend_valid_ff <= pend_valid_in;
         total_ff      <= total_in;
         out_valid_ff  <= out_valid_in;
      end
      best_ff <= best_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign empty             = !out_valid_ff;
   assign rsp_data          = out_ff;
   assign status.busy       = (state_ff != ST_IDLE);
   assign status.edge_count = count_ff;

endmodule

/* rtl/prim_minimum_spanning_tree.sv */
// Top level of the spanning tree engine: front queue, back engine and checks.
// Add and clear transactions are taken one per cycle while no run is in progress.
// A run sweeps the E stored edges once per tree edge and once more to find none, through the
// single read port of the edge store.
// Input stalls while a run is in progress once the two-entry command queue fills.
// Synchronous active-high reset empties the queue and result register and clears count and flag;
// edge store contents are not cleared.
`timescale 1ns / 1ps
module prim_minimum_spanning_tree
   import mst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic       cmd_valid, cmd_pop;
   cmd_type    cmd;
   status_type status;

   mst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   mst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .status    (status)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      status.edge_count <= COUNT_W'(MAX_EDGES))
      else $error("edge count beyond store capacity");

   a_lone_result: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.edge_valid) |-> (rsp_data.last && rsp_data.total_weight == '0))
      else $error("result without a tree edge is not a lone final result");

   a_root_not_child: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.edge_valid) |-> (rsp_data.child_node != '0))
      else $error("root node reported as a newly visited node");

   a_pop_only_busy_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (cmd_valid && !status.busy))
      else $error("command taken while a run is in progress");

endmodule

/* test/tb_prim_minimum_spanning_tree.sv */
// Testbench for the spanning tree engine: random and directed edges, runs and clears, checked.
`timescale 1ns / 1ps
module tb_prim_minimum_spanning_tree;
   import mst_pkg::*;

   // The operation code that the block ignores.
   localparam logic [1:0] OP_SPARE = 2'd3;

   // Scoreboard: keeps a copy of the edge store and predicts the tree for each run.
   class tree_scoreboard;
      edge_type edges[$];
      bit       dropped;
      rsp_type  pending[$];
      int       errors;

      function void note_request(req_type r);
         edge_type     e;
         rsp_type      o;
         logic [15:0]  in_tree;
         logic [TOTAL_W-1:0] total;
         logic [TOTAL_W:0]   sum;
         key_type      best, cand;
         bit           found;
         int           n;
         if (r.operation == OP_ADD) begin
            if (edges.size() >= MAX_EDGES) begin
               dropped = 1;
            end else begin
               e.both_ways = r.both_ways;
               e.from_node = r.from_node;
               e.to_node   = r.to_node;
               e.weight    = r.weight;
               edges = {edges, e};
            end
         end else if (r.operation == OP_CLEAR) begin
            edges.delete();
            dropped = 0;
         end else if (r.operation == OP_RUN) begin
            in_tree = 16'h0001;
            total = '0;
            n = 0;
            forever begin
               found = 0;
               foreach (edges[i]) begin
                  for (int d = 0; d < 2; d++) begin
                     if (d == 1 && !edges[i].both_ways) continue;
                     cand.weight = edges[i].weight;
                     cand.parent = d ? edges[i].to_node : edges[i].from_node;
                     cand.child  = d ? edges[i].from_node : edges[i].to_node;
                     if (!in_tree[cand.parent] || in_tree[cand.child]) continue;
                     if (!found || cand < best) begin
                        best = cand;
                        found = 1;
                     end
                  end
               end
               if (!found) break;
               in_tree[best.child] = 1;
               sum = {1'b0, total} + (TOTAL_W + 1)'(best.weight);
               total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
               o = '0;
               o.parent_node = best.parent;
               o.child_node = best.child;
               o.edge_weight = best.weight;
               o.total_weight = total;
               o.edge_valid = 1;
               o.store_overflowed = dropped;
               pending = {pending, o};
               n++;
            end
            if (n == 0) begin
               o = '0;
               o.store_overflowed = dropped;
               pending = {pending, o};
            end
            pending[$].last = 1;
         end
      endfunction

      function void check_result(rsp_type a);
         rsp_type x;
         if (pending.size() == 0) begin
            $error("unexpected result transaction %h", a);
            errors++;
            return;
         end
         x = pending.pop_front();
         if (a.parent_node !== x.parent_node) begin
            $error("parent_node exp %0d got %0d", x.parent_node, a.parent_node); errors++;
         end
         if (a.child_node !== x.child_node) begin
            $error("child_node exp %0d got %0d", x.child_node, a.child_node); errors++;
         end
         if (a.edge_weight !== x.edge_weight) begin
            $error("edge_weight exp %0d got %0d", x.edge_weight, a.edge_weight); errors++;
         end
         if (a.total_weight !== x.total_weight) begin
            $error("total_weight exp %0d got %0d", x.total_weight, a.total_weight); errors++;
         end
         if (a.edge_valid !== x.edge_valid) begin
            $error("edge_valid exp %0d got %0d", x.edge_valid, a.edge_valid); errors++;
         end
         if (a.store_overflowed !== x.store_overflowed) begin
            $error("store_overflowed exp %0d got %0d", x.store_overflowed,
                   a.store_overflowed);
            errors++;
         end
         if (a.last !== x.last) begin
            $error("last exp %0d got %0d", x.last, a.last); errors++;
         end
      endfunction
   endclass

   logic    clock, reset, push, full, empty, pop;
   req_type req_data;
   rsp_type rsp_data;
   tree_scoreboard board;
   bit      calm;
   int      hold_cycles;

   prim_minimum_spanning_tree dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Drives one transaction and waits until it is taken; push stays high into the next one.
   task automatic send_item(req_type r);
      while (!calm && $urandom_range(99) < 22) begin
         push <= 0;
         @(negedge clock);
      end
      push <= 1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      board.note_request(r);
      @(negedge clock);
   endtask

   task automatic send_edge(int a, int b, int w, bit bw);
      req_type r;
      r.operation = OP_ADD;
      r.from_node = NODE_W'(a);
      r.to_node = NODE_W'(b);
      r.weight = WEIGHT_W'(w);
      r.both_ways = bw;
      send_item(r);
   endtask

   task automatic send_cmd(logic [1:0] op);
      req_type r;
      r = req_type'($urandom);
      r.operation = op;
      send_item(r);
   endtask

   // Mostly connected graphs over a few nodes, plus noise.
   task automatic random_graph();
      int nodes, cnt;
      nodes = $urandom_range(15, 2);
      cnt = ($urandom_range(9) == 0) ? $urandom_range(40, 30) : $urandom_range(nodes + 6, 1);
      send_cmd(OP_CLEAR);
      for (int i = 0; i < cnt; i++) begin
         if ($urandom_range(7) == 0)
            send_edge($urandom_range(15), $urandom_range(15), $urandom, $urandom_range(1));
         else
            send_edge($urandom_range(nodes), $urandom_range(nodes),
                      $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(20),
                      $urandom_range(3) != 0);
      end
      if ($urandom_range(9) == 0) send_cmd(OP_SPARE);
      send_cmd(OP_RUN);
   endtask

   // Receiver: random stalls, with one long hold-off requested by the sender.
   initial begin
      pop = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            pop <= 0;
            hold_cycles--;
         end else begin
            pop <= calm || $urandom_range(99) >= 22;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) board.check_result(rsp_data);
   end

   initial begin
      board = new();
      push = 0;
      req_data = '0;
      reset = 1;
      calm = 0;
      hold_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // Directed part: lone node, ties, one-way edges, extremes, overflow.
      send_cmd(OP_RUN);
      send_edge(0, 1, 5, 1);
      send_edge(0, 2, 5, 1);
      send_edge(1, 2, 5, 0);
      send_edge(2, 3, 65535, 0);
      send_edge(15, 0, 65535, 1);
      send_edge(3, 15, 0, 0);
      send_edge(0, 4, 1, 0);
      send_edge(4, 0, 0, 0);
      send_cmd(OP_SPARE);
      send_cmd(OP_RUN);
      for (int i = 0; i < 26; i++) send_edge(i % 15 + 1, i % 15, 65535 - i, 1);
      send_cmd(OP_RUN);
      send_cmd(OP_CLEAR);
      send_edge(5, 6, 3, 1);
      send_cmd(OP_RUN);
      // Long hold-off on the receiver while runs keep arriving.
      hold_cycles = 400;
      repeat (4) send_cmd(OP_RUN);
      for (int g = 0; g < 23; g++) begin
         calm = (g >= 12 && g < 18);
         random_graph();
      end
      push <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("** prim_minimum_spanning_tree: PASSED **");
      else
         $display("** prim_minimum_spanning_tree: FAILED **");
      $finish;
   end

   initial begin
      #20ms;
      $display("** prim_minimum_spanning_tree: FAILED **");
      $finish;
   end

endmodule
